### rtl/core/satro_pkg.sv
// Package for the rectangle/polygon separating-axis block.
// Holds constants, status codes and the controller/datapath command types.
`timescale 1ns / 1ps
`default_nettype none
package satro_pkg;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_WIDTH_DEF  = 24;
    localparam int RECT_DEPTH       = 4;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_FEW_RECT = 2'd2
    } status_t;

    typedef struct packed {
        logic load_rect;
        logic load_obst;
        logic axis_start;
        logic proj_rect;
        logic proj_obst;
        logic proj_first;
        logic eval_axis;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic rect_full;
        logic obst_full;
        logic overflow;
        logic few_rect;
        logic separated;
        logic rect_idx_end;
        logic obst_idx_end;
        logic obst_single;
        logic axis_end;
    } dp_stat_t;
endpackage
`default_nettype wire

### rtl/core/sat_rect_polygon_overlap.sv
// Top level of the rectangle/polygon separating-axis overlap test.
// Depends on satro_pkg, satro_ctrl, satro_datapath and satro_ram.
//
//  channel  signals                              direction
//  input    in_valid/in_ready, mode, x/y, last   request in
//  output   out_valid/out_ready, collides, status  request out
//
// A corner or non-final vertex is stored when accepted. A final vertex runs a
// test over the axes, paced by one shared two-stage multiply unit reading
// the vertex RAM one entry a cycle.
// Reset clears counts and handshakes; no clearing pass. The result waits in
// its register; no new request is taken until it is delivered.
`timescale 1ns / 1ps
`default_nettype none
module sat_rect_polygon_overlap #(
    parameter int MAX_VERTICES = satro_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = satro_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic signed [COORD_WIDTH-1:0] x_coord,
    input  wire logic signed [COORD_WIDTH-1:0] y_coord,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               collides,
    output logic [1:0]                         status
);
    import satro_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    satro_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .last     (last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .collides (collides),
        .status   (status),
        .cmd      (cmd),
        .stat     (stat)
    );

    satro_datapath #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .x_coord(x_coord),
        .y_coord(y_coord),
        .cmd    (cmd),
        .stat   (stat)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_OVERFLOW
                       || status == STATUS_FEW_RECT)) else $error("bad status");
    a_collide_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> !collides)
        else $error("collides set with error status");
endmodule
`default_nettype wire

### rtl/core/satro_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module satro_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/core/satro_datapath.sv
// Datapath: vertex stores, axis generation, projection min/max and compare.
// Depends on satro_pkg and satro_ram.
`timescale 1ns / 1ps
`default_nettype none
module satro_datapath #(
    parameter int MAX_VERTICES = satro_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = satro_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [COORD_WIDTH-1:0] x_coord,
    input  wire logic signed [COORD_WIDTH-1:0] y_coord,
    input  wire satro_pkg::dp_cmd_t            cmd,
    output satro_pkg::dp_stat_t                stat
);
    import satro_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW + 1;
    localparam int MW  = 2 * COORD_WIDTH;

    logic [2:0]   rcnt_reg, rcnt_next;
    logic [CW-1:0] ocnt_reg, ocnt_next;
    logic          ovf_reg, ovf_next;
    logic [MW-1:0] rect_reg [RECT_DEPTH];

    // Axis counter: 0,1 rectangle edges, 2.. obstacle edges.
    logic [CW:0]   axis_reg, axis_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic signed [DW-1:0] ax_reg, ay_reg;
    logic signed [PW-1:0] rlo_reg, rhi_reg, olo_reg, ohi_reg;
    logic sep_reg;

    logic [AW-1:0] raddr;
    logic [MW-1:0] rdata;
    logic          ram_we;

    assign ram_we = cmd.load_obst && (ocnt_reg < CW'(MAX_VERTICES));

    satro_ram #(.WIDTH(MW), .DEPTH(MAX_VERTICES)) u_obst (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ocnt_reg[AW-1:0]),
        .wdata({x_coord, y_coord}),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Read address: during axis setup the edge start/end vertex,
    // during obstacle projection the running index.
    logic [CW:0] edge_i;
    always_comb
    begin
        edge_i = axis_reg - (CW + 1)'(1);
        if (cmd.proj_obst)
        begin
            raddr = idx_next[AW-1:0];
        end
        else
        begin
            raddr = edge_i[AW-1:0];
        end
    end

    // Edge endpoints: rectangle axes come from registers; obstacle axes
    // use the previous RAM read word latched as point A.
    logic [MW-1:0] pa_reg;
    logic signed [COORD_WIDTH-1:0] pax, pay, pbx, pby;
    always_comb
    begin
        if (axis_reg == '0)
        begin
            {pax, pay} = rect_reg[0];
            {pbx, pby} = rect_reg[1];
        end
        else if (axis_reg == (CW + 1)'(1))
        begin
            {pax, pay} = rect_reg[1];
            {pbx, pby} = rect_reg[2];
        end
        else
        begin
            {pax, pay} = pa_reg;
            {pbx, pby} = rdata;
        end
    end

    // Projection of the current point.
    logic [MW-1:0] pt;
    logic signed [COORD_WIDTH-1:0] ptx, pty;
    logic signed [PW-1:0] d;
    logic signed [PW-2:0] mx_reg, my_reg;
    logic [1:0] rsel;
    logic obst_rd_reg, obst_first_rd_reg;
    logic mul_valid, mul_rect, mul_first;
    assign rsel      = idx_next[1:0];
    assign mul_valid = cmd.proj_rect || obst_rd_reg;
    assign mul_rect  = cmd.proj_rect;
    assign mul_first = (cmd.proj_rect && cmd.proj_first) || obst_first_rd_reg;
    always_comb
    begin
        pt = obst_rd_reg ? rdata : rect_reg[rsel];
        {ptx, pty} = pt;
        d = PW'(mx_reg) + PW'(my_reg);
    end
    logic pend_reg, pend_rect_reg, pend_first_reg;

    logic signed [PW-1:0] lo_a, hi_a, lo_b, hi_b;
    always_comb
    begin
        if (rlo_reg < olo_reg)
        begin
            lo_a = olo_reg;
            hi_a = rhi_reg;
        end
        else
        begin
            lo_a = rlo_reg;
            hi_a = ohi_reg;
        end
        lo_b = '0;
        hi_b = '0;
    end
    logic signed [PW:0] gap;
    assign gap = (PW + 1)'(lo_a) - (PW + 1)'(hi_a);

    always_comb
    begin
        rcnt_next = rcnt_reg;
        ocnt_next = ocnt_reg;
        ovf_next  = ovf_reg;
        axis_next = axis_reg;
        idx_next  = idx_reg;
        if (cmd.load_rect && rcnt_reg < 3'(RECT_DEPTH))
        begin
            rcnt_next = rcnt_reg + 3'd1;
        end
        if (cmd.load_obst)
        begin
            if (ram_we)
            begin
                ocnt_next = ocnt_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.axis_start)
        begin
            idx_next = '0;
        end
        else if (cmd.proj_rect || cmd.proj_obst)
        begin
            idx_next = (cmd.proj_first) ? '0 : idx_reg + CW'(1);
        end
        if (cmd.eval_axis)
        begin
            axis_next = axis_reg + (CW + 1)'(1);
        end
        if (cmd.clear)
        begin
            rcnt_next = '0;
            ocnt_next = '0;
            ovf_next  = 1'b0;
            axis_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg          <= '0;
            ocnt_reg          <= '0;
            ovf_reg           <= 1'b0;
            axis_reg          <= '0;
            idx_reg           <= '0;
            pend_reg          <= 1'b0;
            obst_rd_reg       <= 1'b0;
            obst_first_rd_reg <= 1'b0;
        end
        else
        begin
            rcnt_reg          <= rcnt_next;
            ocnt_reg          <= ocnt_next;
            ovf_reg           <= ovf_next;
            axis_reg          <= axis_next;
            idx_reg           <= idx_next;
            pend_reg          <= mul_valid;
            obst_rd_reg       <= cmd.proj_obst;
            obst_first_rd_reg <= cmd.proj_obst && cmd.proj_first;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rect && rcnt_reg < 3'(RECT_DEPTH))
        begin
            rect_reg[rcnt_reg[1:0]] <= {x_coord, y_coord};
        end
        if (cmd.axis_start)
        begin
            ax_reg <= DW'(pby) - DW'(pay);
            ay_reg <= DW'(pax) - DW'(pbx);
            pa_reg <= rdata;
        end
        // Stage 1: multiply; stage 2: sum and min/max.
        mx_reg <= (PW - 1)'(ptx) * (PW - 1)'(ax_reg);
        my_reg <= (PW - 1)'(pty) * (PW - 1)'(ay_reg);
        pend_rect_reg  <= mul_rect;
        pend_first_reg <= mul_first;
        if (pend_reg)
        begin
            if (pend_rect_reg)
            begin
                if (pend_first_reg || d < rlo_reg) rlo_reg <= d;
                if (pend_first_reg || d > rhi_reg) rhi_reg <= d;
            end
            else
            begin
                if (pend_first_reg || d < olo_reg) olo_reg <= d;
                if (pend_first_reg || d > ohi_reg) ohi_reg <= d;
            end
        end
        if (cmd.eval_axis)
        begin
            sep_reg <= !(gap < 0);
        end
    end

    logic unused_b;
    assign unused_b = |{lo_b, hi_b};

    always_comb
    begin
        stat.rect_full    = (rcnt_reg == 3'(RECT_DEPTH));
        stat.obst_full    = (ocnt_reg == CW'(MAX_VERTICES)) || unused_b;
        stat.overflow     = ovf_reg;
        stat.few_rect     = (rcnt_reg < 3'd3);
        stat.separated    = sep_reg;
        stat.rect_idx_end = ((CW + 2)'(idx_reg) + (CW + 2)'(2) >= (CW + 2)'(rcnt_reg));
        stat.obst_idx_end = ((CW + 1)'(idx_reg) + (CW + 1)'(2) >= (CW + 1)'(ocnt_reg));
        stat.obst_single  = (ocnt_reg <= CW'(1));
        stat.axis_end     = (axis_reg >= ((CW + 1)'(ocnt_reg) + (CW + 1)'(1)));
    end
endmodule
`default_nettype wire

### rtl/core/satro_ctrl.sv
// Controller state machine sequencing loads, axes, projections and result.
// Depends on satro_pkg.
`timescale 1ns / 1ps
`default_nettype none
module satro_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                mode,
    input  wire logic                last,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     collides,
    output logic [1:0]               status,
    output satro_pkg::dp_cmd_t       cmd,
    input  wire satro_pkg::dp_stat_t stat
);
    import satro_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_AXRD  = 8'b0000_0010,
        S_AXIS  = 8'b0000_0100,
        S_PRECT = 8'b0000_1000,
        S_POBST = 8'b0001_0000,
        S_DRAIN = 8'b0010_0000,
        S_EVAL  = 8'b0100_0000,
        S_CHECK = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] drain_reg, drain_next;
    logic first_reg, first_next;
    logic ov_reg, ov_next;
    logic col_reg, col_next;
    logic [1:0] st_reg, st_next;
    logic acc;

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign acc       = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign collides  = col_reg;
    assign status    = st_reg;

    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        first_next = first_reg;
        ov_next    = ov_reg;
        col_next   = col_reg;
        st_next    = st_reg;
        cmd        = '0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    cmd.load_rect = !mode;
                    cmd.load_obst = mode;
                    if (mode && last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.overflow)
                begin
                    ov_next = 1'b1; col_next = 1'b0; st_next = STATUS_OVERFLOW;
                    cmd.clear = 1'b1; state_next = S_IDLE;
                end
                else if (stat.few_rect)
                begin
                    ov_next = 1'b1; col_next = 1'b0; st_next = STATUS_FEW_RECT;
                    cmd.clear = 1'b1; state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_AXRD;
                end
            end
            S_AXRD:
            begin
                state_next = S_AXIS;
            end
            S_AXIS:
            begin
                cmd.axis_start = 1'b1;
                first_next = 1'b1;
                state_next = S_PRECT;
            end
            S_PRECT:
            begin
                cmd.proj_rect  = 1'b1;
                cmd.proj_first = first_reg;
                first_next     = 1'b0;
                if (!first_reg && stat.rect_idx_end)
                begin
                    first_next = 1'b1;
                    state_next = S_POBST;
                end
            end
            S_POBST:
            begin
                cmd.proj_obst  = 1'b1;
                cmd.proj_first = first_reg;
                first_next     = 1'b0;
                if (first_reg ? stat.obst_single : stat.obst_idx_end)
                begin
                    drain_next = 2'd2;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg - 2'd1;
                if (drain_reg == 2'd1)
                begin
                    drain_next = 2'd1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval_axis = 1'b1;
                state_next = S_DRAIN;
                drain_next = 2'd0;
                if (drain_reg == 2'd0)
                begin
                    cmd.eval_axis = 1'b0;
                    if (stat.separated || stat.axis_end)
                    begin
                        ov_next = 1'b1; col_next = !stat.separated;
                        st_next = STATUS_OK;
                        cmd.clear = 1'b1; state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_AXRD;
                    end
                end
                else
                begin
                    drain_next = 2'd0;
                    state_next = S_EVAL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            drain_reg <= '0;
            first_reg <= 1'b0;
            ov_reg    <= 1'b0;
            col_reg   <= 1'b0;
            st_reg    <= STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
            first_reg <= first_next;
            ov_reg    <= ov_next;
            col_reg   <= col_next;
            st_reg    <= st_next;
        end
    end
endmodule
`default_nettype wire
